// File: hdl/arr_pkg.sv
// shared types and constants of the annulus ring rasterizer
`default_nettype none
package arr_pkg;

	// default chunk edge in cells; the design takes 8 to 64
	localparam int CHUNK_EDGE_DEF = 64;
	// width of a row or column index field, sized for the largest edge
	localparam int COL_IDX_W = 6;
	// signed offset from the ring center in Q.8 pixels
	localparam int DW = 26;
	// offsets at or beyond this many bits always land outside the ring
	localparam int SQ_IN_W = 17;
	localparam int SQ_W = 2 * SQ_IN_W;
	// 400 times a squared offset, saturated at Q_SAT
	localparam int LW = 43;
	localparam int SUM_W = LW + 1;
	// (9s)^2 and (9s+20t)^2
	localparam int LO_W = 23;
	localparam int HI_W = 26;
	localparam int THR_SHIFT = 16;
	localparam int NBANK = 2;
	// larger than any outer threshold, so a saturated lane never hits
	localparam logic [LW-1:0] Q_SAT = {1'b1, {(LW - 1){1'b0}}};

	typedef enum logic [1:0] {
		CFG_FILL_MATERIAL,
		CFG_RING_THICKNESS,
		CFG_CHUNK_COL,
		CFG_CHUNK_ROW
	} cfg_reg_e;

	typedef struct packed {
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic [7:0] size_class;
		logic ring_flag;
	} stamp_t;

	typedef struct packed {
		logic [5:0] row_index;
		logic [63:0] cell_mask;
		logic [7:0] material;
		logic last_row;
	} row_t;

	typedef struct packed {
		cfg_reg_e index;
		logic [9:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic signed [DW-1:0] dy0;
		logic [LO_W-1:0] lo_base;
		logic [HI_W-1:0] hi_base;
	} bank_param_t;

	typedef struct packed {
		logic valid;
		logic bank;
		bank_param_t param;
	} param_wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
		logic [COL_IDX_W-1:0] col;
		logic [LW-1:0] data;
	} col_wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_ev_t;

endpackage
`default_nettype wire

// File: hdl/arr_chan_if.sv
// valid/ready channel carrying one item of a given payload type
`default_nettype none
interface arr_chan_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/annulus_ring_raster.sv
// annulus ring rasterizer top level: config registers, column unit, banks, row pipeline
// a stamp with the ring flag clear is taken and dropped without producing any rows
// throughput: set by the column unit filling one lane bank a column per cycle and by
//   the row pipeline emitting one row per cycle while the receiver keeps taking rows
// reset: arst_n clears config registers, bank full flags and all pipeline valid bits;
//   lane banks need no clearing since a bank is only read after it is filled
`default_nettype none
module annulus_ring_raster #(
	parameter int CHUNK_EDGE = arr_pkg::CHUNK_EDGE_DEF
) (
	input logic clk,
	input logic arst_n,
	arr_chan_if.sink stamps,
	arr_chan_if.sink cfg,
	arr_chan_if.source rows
);

	// configuration registers
	logic [7:0] fill_material_q;
	logic [7:0] ring_thickness_q;
	logic signed [9:0] chunk_col_q;
	logic signed [9:0] chunk_row_q;

	// column unit to banks
	arr_pkg::col_wr_t col_wr;
	arr_pkg::param_wr_t param_wr;
	arr_pkg::bank_ev_t fill_done;

	// banks to row pipeline and back
	arr_pkg::bank_ev_t bank_free;
	logic [arr_pkg::NBANK-1:0] bank_full;
	arr_pkg::bank_param_t bank_param [arr_pkg::NBANK];
	logic [arr_pkg::LW-1:0] lanes [CHUNK_EDGE];
	logic rd_sel;

	// writes are taken every cycle; the user writes only while idle; the block does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_material_q <= '0;
			ring_thickness_q <= '0;
			chunk_col_q <= '0;
			chunk_row_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				arr_pkg::CFG_FILL_MATERIAL: begin
					fill_material_q <= cfg.data.wdata[7:0];
				end
				arr_pkg::CFG_RING_THICKNESS: begin
					ring_thickness_q <= cfg.data.wdata[7:0];
				end
				arr_pkg::CFG_CHUNK_COL: begin
					chunk_col_q <= $signed(cfg.data.wdata);
				end
				arr_pkg::CFG_CHUNK_ROW: begin
					chunk_row_q <= $signed(cfg.data.wdata);
				end
			endcase
		end
	end

	// stamp intake: 400*dx^2 for every column of the chunk, one column a cycle,
	// into whichever bank the row side has released; thresholds are
	// (9s)^2 and (9s+20t)^2 scaled by 2^16, matching 400*d^2 against the radii
	arr_colgen #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) u_colgen (
		.clk(clk),
		.arst_n(arst_n),
		.stamps(stamps),
		.ring_thickness(ring_thickness_q),
		.chunk_col(chunk_col_q),
		.chunk_row(chunk_row_q),
		.bank_full(bank_full),
		.col_wr(col_wr),
		.param_wr(param_wr),
		.fill_done(fill_done)
	);

	// two banks so the next stamp fills while the current one is drawn
	arr_bank #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) u_bank (
		.clk(clk),
		.arst_n(arst_n),
		.col_wr(col_wr),
		.param_wr(param_wr),
		.fill_done(fill_done),
		.bank_free(bank_free),
		.rd_sel(rd_sel),
		.bank_full(bank_full),
		.bank_param(bank_param),
		.lanes(lanes)
	);

	// one row per cycle unless the output stalls: 400*dy^2 added to every lane and tested against the
	// inner and outer thresholds, result held in the output register
	arr_rowgen #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) u_rowgen (
		.clk(clk),
		.arst_n(arst_n),
		.bank_full(bank_full),
		.bank_param(bank_param),
		.lanes(lanes),
		.material(fill_material_q),
		.rd_sel(rd_sel),
		.bank_free(bank_free),
		.rows(rows)
	);

`ifndef SYNTHESIS
	// the column unit never overwrites a bank that is still being drawn
	assert property (@(posedge clk) disable iff (!arst_n)
		col_wr.valid |-> !bank_full[col_wr.bank])
		else $error("column write into a full bank");

	// the row side only releases a bank that was filled
	assert property (@(posedge clk) disable iff (!arst_n)
		bank_free.valid |-> bank_full[bank_free.bank])
		else $error("release of a bank that is not full");

	// rows of one stamp leave back to back in order
	assert property (@(posedge clk) disable iff (!arst_n)
		rows.valid && rows.ready && !rows.data.last_row |=>
		rows.valid && (rows.data.row_index == $past(rows.data.row_index) + 6'd1))
		else $error("gap or misorder inside the rows of one stamp");
`endif

endmodule
`default_nettype wire

// File: hdl/arr_sq400.sv
// two-stage unit: 400 times the square of a signed offset, saturated
`default_nettype none
module arr_sq400 #(
	parameter int TAG_W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [arr_pkg::DW-1:0] in_val,
	input logic [TAG_W-1:0] in_tag,
	output logic out_valid,
	output logic [arr_pkg::LW-1:0] out_q,
	output logic [TAG_W-1:0] out_tag
);

	logic [arr_pkg::DW-1:0] mag;
	logic over;
	logic [arr_pkg::LW-1:0] wide;
	logic [arr_pkg::LW-1:0] prod;
	logic [arr_pkg::LW-1:0] scaled;

	logic valid_s1;
	logic over_s1;
	logic [arr_pkg::SQ_W-1:0] sq_s1;
	logic [TAG_W-1:0] tag_s1;
	logic valid_s2;
	logic [arr_pkg::LW-1:0] q_s2;
	logic [TAG_W-1:0] tag_s2;

	always_comb begin
		mag = in_val[arr_pkg::DW-1] ? $unsigned(-in_val) : $unsigned(in_val);
		over = |mag[arr_pkg::DW-1:arr_pkg::SQ_IN_W];
	end

	// 400 = 256 + 128 + 16
	always_comb begin
		wide = arr_pkg::LW'(sq_s1);
		prod = (wide << 8) + (wide << 7) + (wide << 4);
		scaled = (over_s1 || prod > arr_pkg::Q_SAT) ? arr_pkg::Q_SAT : prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			over_s1 <= over;
			sq_s1 <= arr_pkg::SQ_W'(mag[arr_pkg::SQ_IN_W-1:0])
				* arr_pkg::SQ_W'(mag[arr_pkg::SQ_IN_W-1:0]);
			tag_s1 <= in_tag;
			q_s2 <= scaled;
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_q = q_s2;
	assign out_tag = tag_s2;

endmodule
`default_nettype wire

// File: hdl/arr_colgen.sv
// stamp intake and column unit: fills one lane bank per stamp, a column a cycle
`default_nettype none
module arr_colgen #(
	parameter int CHUNK_EDGE = arr_pkg::CHUNK_EDGE_DEF
) (
	input logic clk,
	input logic arst_n,
	arr_chan_if.sink stamps,
	input logic [7:0] ring_thickness,
	input logic signed [9:0] chunk_col,
	input logic signed [9:0] chunk_row,
	input logic [arr_pkg::NBANK-1:0] bank_full,
	output arr_pkg::col_wr_t col_wr,
	output arr_pkg::param_wr_t param_wr,
	output arr_pkg::bank_ev_t fill_done
);

	localparam int CW = $clog2(CHUNK_EDGE);
	localparam int TAG_W = arr_pkg::COL_IDX_W + 2;

	arr_pkg::stamp_t stamp_s1;
	logic valid_s1;

	logic act_q;
	logic [CW-1:0] cnt_q;
	logic wsel_q;
	logic bank_q;
	logic signed [arr_pkg::DW-1:0] dx0_q;

	logic valid_s2;
	logic signed [arr_pkg::DW-1:0] dx_s2;
	logic [TAG_W-1:0] tag_s2;

	logic last_col;
	logic start;
	logic take;
	logic signed [arr_pkg::DW-1:0] org_x;
	logic signed [arr_pkg::DW-1:0] org_y;
	logic signed [arr_pkg::DW-1:0] dx0;
	logic signed [arr_pkg::DW-1:0] dy0;
	logic [11:0] nine_s;
	logic [12:0] outer_lin;

	logic sq_valid;
	logic [arr_pkg::LW-1:0] sq_q;
	logic [TAG_W-1:0] sq_tag;

	// a new stamp starts once the previous one has issued its last column
	// and the next bank has been released by the row side
	always_comb begin
		last_col = act_q && (cnt_q == CW'(CHUNK_EDGE - 1));
		start = valid_s1 && stamp_s1.ring_flag && (!act_q || last_col)
			&& !bank_full[wsel_q];
		take = valid_s1 && (!stamp_s1.ring_flag || start);
		stamps.ready = !valid_s1 || take;
	end

	// chunk origin and center offsets, Q.8
	always_comb begin
		org_x = arr_pkg::DW'(chunk_col) * arr_pkg::DW'(CHUNK_EDGE);
		org_y = arr_pkg::DW'(chunk_row) * arr_pkg::DW'(CHUNK_EDGE);
		dx0 = (org_x <<< 8) - arr_pkg::DW'($signed(stamp_s1.center_x));
		dy0 = (org_y <<< 8) - arr_pkg::DW'($signed(stamp_s1.center_y));
		nine_s = (12'(stamp_s1.size_class) << 3) + 12'(stamp_s1.size_class);
		outer_lin = 13'(nine_s) + (13'(ring_thickness) << 4) + (13'(ring_thickness) << 2);
	end

	// stamp parameters go to the bank that this stamp will fill
	always_comb begin
		param_wr.valid = start;
		param_wr.bank = wsel_q;
		param_wr.param.dy0 = dy0;
		param_wr.param.lo_base = arr_pkg::LO_W'(24'(nine_s) * 24'(nine_s));
		param_wr.param.hi_base = arr_pkg::HI_W'(26'(outer_lin) * 26'(outer_lin));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			act_q <= 1'b0;
			cnt_q <= '0;
			wsel_q <= 1'b0;
			bank_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (stamps.valid && stamps.ready) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
				bank_q <= wsel_q;
				wsel_q <= ~wsel_q;
			end else if (last_col) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			valid_s2 <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stamps.valid && stamps.ready) begin
			stamp_s1 <= stamps.data;
		end
		if (start) begin
			dx0_q <= dx0;
		end
		dx_s2 <= dx0_q + $signed(arr_pkg::DW'({cnt_q, 8'h00}));
		tag_s2 <= {bank_q, arr_pkg::COL_IDX_W'(cnt_q), last_col};
	end

	arr_sq400 #(
		.TAG_W(TAG_W)
	) u_sq (
		.clk(clk),
		.arst_n(arst_n),
		.en(1'b1),
		.in_valid(valid_s2),
		.in_val(dx_s2),
		.in_tag(tag_s2),
		.out_valid(sq_valid),
		.out_q(sq_q),
		.out_tag(sq_tag)
	);

	always_comb begin
		col_wr.valid = sq_valid;
		col_wr.bank = sq_tag[TAG_W-1];
		col_wr.col = sq_tag[TAG_W-2:1];
		col_wr.data = sq_q;
		fill_done.valid = sq_valid && sq_tag[0];
		fill_done.bank = sq_tag[TAG_W-1];
	end

endmodule
`default_nettype wire

// File: hdl/arr_bank.sv
// double-buffered lane banks with per-bank stamp parameters and full flags
`default_nettype none
module arr_bank #(
	parameter int CHUNK_EDGE = arr_pkg::CHUNK_EDGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input arr_pkg::col_wr_t col_wr,
	input arr_pkg::param_wr_t param_wr,
	input arr_pkg::bank_ev_t fill_done,
	input arr_pkg::bank_ev_t bank_free,
	input logic rd_sel,
	output logic [arr_pkg::NBANK-1:0] bank_full,
	output arr_pkg::bank_param_t bank_param [arr_pkg::NBANK],
	output logic [arr_pkg::LW-1:0] lanes [CHUNK_EDGE]
);

	localparam int CW = $clog2(CHUNK_EDGE);

	logic [arr_pkg::LW-1:0] lane_q [arr_pkg::NBANK][CHUNK_EDGE];
	arr_pkg::bank_param_t param_q [arr_pkg::NBANK];
	logic [arr_pkg::NBANK-1:0] full_q;

	always_ff @(posedge clk) begin
		if (col_wr.valid) begin
			lane_q[col_wr.bank][col_wr.col[CW-1:0]] <= col_wr.data;
		end
		if (param_wr.valid) begin
			param_q[param_wr.bank] <= param_wr.param;
		end
	end

	// the two sides never touch the same bank in one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else begin
			if (fill_done.valid) begin
				full_q[fill_done.bank] <= 1'b1;
			end
			if (bank_free.valid) begin
				full_q[bank_free.bank] <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CHUNK_EDGE; i++) begin
			lanes[i] = lane_q[rd_sel][i];
		end
	end

	assign bank_full = full_q;
	assign bank_param = param_q;

endmodule
`default_nettype wire

// File: hdl/arr_rowgen.sv
// row pipeline: row offset, square, lane compare and output register
`default_nettype none
module arr_rowgen #(
	parameter int CHUNK_EDGE = arr_pkg::CHUNK_EDGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [arr_pkg::NBANK-1:0] bank_full,
	input arr_pkg::bank_param_t bank_param [arr_pkg::NBANK],
	input logic [arr_pkg::LW-1:0] lanes [CHUNK_EDGE],
	input logic [7:0] material,
	output logic rd_sel,
	output arr_pkg::bank_ev_t bank_free,
	arr_chan_if.source rows
);

	localparam int CW = $clog2(CHUNK_EDGE);
	localparam int TAG_W = arr_pkg::COL_IDX_W + 2;

	logic adv;
	logic issue;
	logic last_issue;
	logic rsel_q;
	logic [CW-1:0] y_q;

	logic valid_s1;
	logic signed [arr_pkg::DW-1:0] dy_s1;
	logic [TAG_W-1:0] tag_s1;

	logic valid_s3;
	logic [arr_pkg::LW-1:0] q_s3;
	logic [TAG_W-1:0] tag_s3;
	logic bank_s3;
	logic last_s3;

	logic [arr_pkg::SUM_W-1:0] lo_th;
	logic [arr_pkg::SUM_W-1:0] hi_th;
	logic [arr_pkg::SUM_W-1:0] lane_sum [CHUNK_EDGE];
	logic [CHUNK_EDGE-1:0] hit;

	logic valid_s4;
	logic [CHUNK_EDGE-1:0] mask_s4;
	logic [arr_pkg::COL_IDX_W-1:0] row_s4;
	logic last_s4;

	// all stages move together when the output register can take a row
	always_comb begin
		adv = !valid_s4 || rows.ready;
		issue = adv && bank_full[rsel_q];
		last_issue = (y_q == CW'(CHUNK_EDGE - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsel_q <= 1'b0;
			y_q <= '0;
			valid_s1 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (issue) begin
				if (last_issue) begin
					y_q <= '0;
					rsel_q <= ~rsel_q;
				end else begin
					y_q <= y_q + 1'b1;
				end
			end
			if (adv) begin
				valid_s1 <= bank_full[rsel_q];
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dy_s1 <= bank_param[rsel_q].dy0 + $signed(arr_pkg::DW'({y_q, 8'h00}));
			tag_s1 <= {rsel_q, arr_pkg::COL_IDX_W'(y_q), last_issue};
		end
	end

	arr_sq400 #(
		.TAG_W(TAG_W)
	) u_sq (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(valid_s1),
		.in_val(dy_s1),
		.in_tag(tag_s1),
		.out_valid(valid_s3),
		.out_q(q_s3),
		.out_tag(tag_s3)
	);

	assign bank_s3 = tag_s3[TAG_W-1];
	assign last_s3 = tag_s3[0];
	assign rd_sel = bank_s3;

	// every cell of the row against both thresholds at once
	always_comb begin
		lo_th = arr_pkg::SUM_W'(bank_param[bank_s3].lo_base) << arr_pkg::THR_SHIFT;
		hi_th = arr_pkg::SUM_W'(bank_param[bank_s3].hi_base) << arr_pkg::THR_SHIFT;
		for (int i = 0; i < CHUNK_EDGE; i++) begin
			lane_sum[i] = arr_pkg::SUM_W'(lanes[i]) + arr_pkg::SUM_W'(q_s3);
			hit[i] = (lane_sum[i] >= lo_th) && (lane_sum[i] < hi_th);
		end
	end

	// the bank is read for the last time as its last row enters the output stage
	always_comb begin
		bank_free.valid = valid_s3 && last_s3 && adv;
		bank_free.bank = bank_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s4 <= hit;
			row_s4 <= tag_s3[TAG_W-2:1];
			last_s4 <= last_s3;
		end
	end

	always_comb begin
		rows.valid = valid_s4;
		rows.data.row_index = row_s4;
		rows.data.cell_mask = 64'(mask_s4);
		rows.data.material = material;
		rows.data.last_row = last_s4;
	end

endmodule
`default_nettype wire

// File: bench/tb_annulus_ring_raster.sv
`timescale 1ns / 100ps
// self-checking testbench of the annulus ring rasterizer, with a row scoreboard and predictor
module tb_annulus_ring_raster;
	import arr_pkg::*;

	localparam int EDGE = CHUNK_EDGE_DEF;
	// long enough for the rows of a stamp to drain from the pipeline, plus some slack
	localparam int SETTLE = 2 * EDGE + 16;
	// generous: about 300 drawn stamps, 64 rows each, slowed by stalls, taken several times over
	localparam int LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 6;
	localparam int STAMPS_PER_PHASE = 44;

	// traffic shaping of each phase
	typedef enum int {
		FLOW_FREE,
		FLOW_SRC_GAPS,
		FLOW_SNK_STALLS,
		FLOW_BOTH
	} flow_e;

	// mirror of the register file, queue of expected rows and the ring predictor
	class ring_row_board;
		row_t pending_rows[$];
		logic [7:0] fill;
		logic [7:0] thick;
		logic signed [9:0] ccol;
		logic signed [9:0] crow;
		int errors;
		int rows_checked;
		int stamps_drawn;
		int stamps_skipped;
		int settings;

		function new();
			fill = '0;
			thick = '0;
			ccol = '0;
			crow = '0;
			errors = 0;
			rows_checked = 0;
			stamps_drawn = 0;
			stamps_skipped = 0;
			settings = 0;
		endfunction

		function void note_reg(cfg_reg_e idx, logic [9:0] val);
			case (idx)
				CFG_FILL_MATERIAL: fill = val[7:0];
				CFG_RING_THICKNESS: thick = val[7:0];
				CFG_CHUNK_COL: ccol = val;
				CFG_CHUNK_ROW: crow = val;
				default: ;
			endcase
		endfunction

		function longint unsigned sq_mag(longint v);
			longint unsigned a;
			a = (v < 0) ? longint'(-v) : longint'(v);
			return a * a;
		endfunction

		function int pending();
			return pending_rows.size();
		endfunction

		// squared distances scaled so that the ring test stays in integers
		function void note_stamp(stamp_t st);
			longint cx, cy, ox, oy;
			longint unsigned s, t, lo, hi, dy2, q;
			logic [63:0] mask;
			row_t r;
			if (!st.ring_flag) begin
				stamps_skipped++;
				return;
			end
			stamps_drawn++;
			cx = longint'($signed(st.center_x));
			cy = longint'($signed(st.center_y));
			s = st.size_class;
			t = thick;
			lo = 81 * s * s * 65536;
			hi = (81 * s * s + 360 * s * t + 400 * t * t) * 65536;
			ox = longint'(ccol) * EDGE;
			oy = longint'(crow) * EDGE;
			for (int y = 0; y < EDGE; y++) begin
				dy2 = sq_mag((oy + y) * 256 - cy);
				mask = '0;
				for (int x = 0; x < EDGE; x++) begin
					q = 400 * (sq_mag((ox + x) * 256 - cx) + dy2);
					if (q >= lo && q < hi)
						mask[x] = 1'b1;
				end
				r.row_index = y[5:0];
				r.cell_mask = mask;
				r.material = fill;
				r.last_row = (y == EDGE - 1);
				pending_rows.push_back(r);
			end
		endfunction

		function void check_row(row_t got);
			row_t exp;
			rows_checked++;
			if (pending_rows.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected row item: row %0d mask %h material %h last %b",
						got.row_index, got.cell_mask, got.material, got.last_row);
				return;
			end
			exp = pending_rows.pop_front();
			if (got.row_index !== exp.row_index || got.cell_mask !== exp.cell_mask ||
					got.material !== exp.material || got.last_row !== exp.last_row) begin
				errors++;
				if (errors <= 10)
					$display("row mismatch: expected row %0d mask %h material %h last %b, got row %0d mask %h material %h last %b",
						exp.row_index, exp.cell_mask, exp.material, exp.last_row,
						got.row_index, got.cell_mask, got.material, got.last_row);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	arr_chan_if #(.payload_t(stamp_t)) stamps_if ();
	arr_chan_if #(.payload_t(cfg_t)) cfg_if ();
	arr_chan_if #(.payload_t(row_t)) rows_if ();

	ring_row_board board = new;

	// traffic knobs: sender gap and receiver stall chances in percent
	int src_pct = 0;
	int snk_pct = 0;
	// one long receiver hold-off, requested by the stimulus, timed by the receiver
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	annulus_ring_raster #(.CHUNK_EDGE(EDGE)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stamps(stamps_if),
		.cfg(cfg_if),
		.rows(rows_if)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d rows still expected", cycles, board.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: check the row taken at this edge, then pick ready for the next one
	always @(posedge clk) begin
		if (rows_if.valid && rows_if.ready)
			board.check_row(rows_if.data);
		if (hold_left > 0) begin
			rows_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			// long hold-off so the banks fill and the stamp input backs up
			rows_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rows_if.ready <= ($urandom_range(0, 99) >= snk_pct);
		end
	end

	task automatic set_flow(input flow_e mode);
		case (mode)
			FLOW_FREE: begin
				src_pct = 0;
				snk_pct <= 0;
			end
			FLOW_SRC_GAPS: begin
				src_pct = 63;
				snk_pct <= 0;
			end
			FLOW_SNK_STALLS: begin
				src_pct = 0;
				snk_pct <= 63;
			end
			default: begin
				src_pct = 12;
				snk_pct <= 12;
			end
		endcase
	endtask

	// offer one stamp; valid stays high on return so back-to-back items need no toggle
	task automatic send_stamp(input stamp_t st);
		if ($urandom_range(0, 99) < src_pct) begin
			stamps_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_pct);
		end
		stamps_if.valid <= 1'b1;
		stamps_if.data <= st;
		@(posedge clk);
		while (!stamps_if.ready) @(posedge clk);
		board.note_stamp(st);
	endtask

	task automatic offer(input logic [23:0] x, input logic [23:0] y, input logic [7:0] s,
			input logic f);
		stamp_t st;
		st.center_x = x;
		st.center_y = y;
		st.size_class = s;
		st.ring_flag = f;
		send_stamp(st);
	endtask

	// stop offering, wait for every expected row, then let the pipeline run dry
	task automatic settle_rows();
		stamps_if.valid <= 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [9:0] val);
		cfg_t cw;
		cw.index = idx;
		cw.wdata = val;
		cfg_if.valid <= 1'b1;
		cfg_if.data <= cw;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		board.note_reg(idx, val);
	endtask

	// full register setting, only once the block is idle; unused top bits get noise
	task automatic set_ring_cfg(input logic [7:0] fill, input logic [7:0] thick,
			input logic [9:0] col, input logic [9:0] row);
		logic [9:0] w;
		settle_rows();
		w = $urandom;
		w[7:0] = fill;
		write_reg(CFG_FILL_MATERIAL, w);
		w = $urandom;
		w[7:0] = thick;
		write_reg(CFG_RING_THICKNESS, w);
		write_reg(CFG_CHUNK_COL, col);
		write_reg(CFG_CHUNK_ROW, row);
		cfg_if.valid <= 1'b0;
		board.settings++;
	endtask

	// world pixel plus fraction to Q15.8, clamped to the field range
	function automatic logic [23:0] to_q(input longint px, input int frac);
		longint q;
		q = px * 256 + frac;
		if (q > 8388607)
			q = 8388607;
		if (q < -8388608)
			q = -8388608;
		return q[23:0];
	endfunction

	// center within reach of the current chunk so rings actually cross it
	function automatic stamp_t aimed_stamp();
		stamp_t st;
		longint ox, oy;
		ox = longint'(board.ccol) * EDGE;
		oy = longint'(board.crow) * EDGE;
		st.center_x = to_q(ox + int'($urandom_range(0, 140)) - 40, $urandom_range(0, 255));
		st.center_y = to_q(oy + int'($urandom_range(0, 140)) - 40, $urandom_range(0, 255));
		st.size_class = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 140));
		st.ring_flag = 1'b1;
		return st;
	endfunction

	initial begin
		int goal;
		stamp_t st;
		flow_e mode;
		arst_n = 1'b0;
		stamps_if.valid = 1'b0;
		stamps_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		rows_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset registers: zero thickness leaves every ring empty
		offer('0, '0, '0, 1'b0);
		offer(to_q(32, 0), to_q(32, 0), 8'd0, 1'b1);
		offer(to_q(32, 0), to_q(32, 0), 8'hFF, 1'b1);
		offer(24'hFFFFFF, 24'h7FFFFF, 8'hFF, 1'b0);

		// directed, thin rings in the chunk at the world origin
		set_ring_cfg(8'hA5, 8'd5, 10'd0, 10'd0);
		offer(to_q(32, 0), to_q(32, 0), 8'd40, 1'b1);
		// zero size: a plain disk of radius t
		offer(to_q(32, 128), to_q(31, 64), 8'd0, 1'b1);
		offer(to_q(10, 0), to_q(10, 0), 8'd1, 1'b1);
		offer(24'h7FFFFF, 24'h800000, 8'hFF, 1'b1);
		offer(24'h800000, 24'h7FFFFF, 8'hFF, 1'b1);
		offer(to_q(0, 0), to_q(0, 0), 8'hFF, 1'b1);
		offer(to_q(63, 255), to_q(0, 0), 8'd100, 1'b1);
		// rows outside the ring still come out, with empty masks
		offer(to_q(32, 0), to_q(-30, 0), 8'd20, 1'b1);

		// directed, chunk at the negative x and positive y extremes, widest ring
		set_ring_cfg(8'hFF, 8'hFF, 10'h200, 10'h1FF);
		offer(to_q(-32768 + 20, 0), to_q(32704 + 30, 0), 8'd60, 1'b1);
		offer(24'h800000, 24'h7FFFFF, 8'hFF, 1'b1);
		offer(to_q(-32768 + 32, 0), to_q(32704 + 32, 0), 8'd0, 1'b1);

		// directed, opposite chunk corner, zero thickness written explicitly
		set_ring_cfg(8'h00, 8'h00, 10'h1FF, 10'h200);
		offer(to_q(32704 + 32, 0), to_q(-32768 + 32, 0), 8'd100, 1'b1);
		offer(to_q(32704 + 32, 0), to_q(-32768 + 32, 0), 8'd0, 1'b1);

		// random phases: register setting and traffic shape change per phase
		goal = board.stamps_drawn;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_ring_cfg(8'hFF, 8'hFF, 10'h200, 10'h200);
				1: set_ring_cfg(8'h00, 8'h01, 10'h1FF, 10'h1FF);
				2: set_ring_cfg($urandom, $urandom_range(1, 16), $urandom, $urandom);
				3: set_ring_cfg($urandom, $urandom, $urandom, $urandom);
				default: set_ring_cfg($urandom, $urandom_range(2, 8), $urandom, $urandom);
			endcase
			mode = flow_e'(p % 4);
			set_flow(mode);
			// receiver stall phase also carries the long hold-off
			if (p == 2)
				hold_req <= 1'b1;
			goal += STAMPS_PER_PHASE;
			while (board.stamps_drawn < goal) begin
				case ($urandom_range(0, 9))
					0: begin
						// noise: anywhere in the world
						st = $urandom;
						st.ring_flag = 1'b1;
					end
					1: begin
						st = $urandom;
						st.ring_flag = 1'b0;
					end
					default: st = aimed_stamp();
				endcase
				send_stamp(st);
				// in phase 4 the sender waits for the block to drain at mid-phase
				if (p == 4 && board.stamps_drawn == goal - STAMPS_PER_PHASE / 2)
					settle_rows();
			end
		end

		settle_rows();
		$display("drew %0d ring stamps and skipped %0d over %0d register settings, %0d row items checked",
			board.stamps_drawn, board.stamps_skipped, board.settings, board.rows_checked);
		$display("traffic: free flow, sender gaps, receiver stalls, both, one %0d-cycle hold; %0d mismatches",
			HOLD_CYCLES, board.errors);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: annulus_ring_raster.f
hdl/arr_pkg.sv
hdl/arr_chan_if.sv
hdl/arr_sq400.sv
hdl/arr_colgen.sv
hdl/arr_bank.sv
hdl/arr_rowgen.sv
hdl/annulus_ring_raster.sv
bench/tb_annulus_ring_raster.sv
